/* rtl/tams_pkg.sv */
package tams_pkg;

  localparam int unsigned TicksW = 7;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TGT_NONE     = 2'd0,
    TGT_LEFT     = 2'd1,
    TGT_RIGHT    = 2'd2,
    TGT_STRAIGHT = 2'd3
  } target_t;

  typedef enum logic [2:0] {
    STG_IDLE           = 3'd0,
    STG_TURN_OUT       = 3'd1,
    STG_STRAIGHTEN_OUT = 3'd2,
    STG_DRIVE_PAST     = 3'd3,
    STG_TURN_IN        = 3'd4,
    STG_STRAIGHTEN_IN  = 3'd5,
    STG_UNUSED6        = 3'd6,
    STG_UNUSED7        = 3'd7
  } stage_t;

  localparam logic [TicksW-1:0] DurFirst    = 7'd30;
  localparam logic [TicksW-1:0] DurStraight = 7'd100;

  localparam logic signed [2:0] SteerNeg  = -3'sd2;
  localparam logic signed [2:0] SteerZero = 3'sd0;
  localparam logic signed [2:0] SteerPos  = 3'sd2;

  typedef struct packed {
    func_t   func;
    target_t target_kind;
  } item_t;

  // steering per target and stage
  function automatic logic signed [2:0] steer_of(target_t tgt, stage_t stg);
    logic signed [2:0] s;
    s = SteerZero;
    if (tgt == TGT_LEFT || tgt == TGT_RIGHT) begin
      unique case (stg)
        STG_TURN_OUT, STG_STRAIGHTEN_IN: s = SteerNeg;
        STG_STRAIGHTEN_OUT, STG_TURN_IN: s = SteerPos;
        default:                         s = SteerZero;
      endcase
      if (tgt == TGT_RIGHT) s = -s;
    end
    return s;
  endfunction

  // duration of the stage entered after the given one
  function automatic logic [TicksW-1:0] next_dur(target_t tgt, stage_t stg);
    logic [TicksW-1:0] d;
    d = '0;
    if (tgt == TGT_LEFT) begin
      unique case (stg)
        STG_TURN_OUT:       d = 7'd15;
        STG_STRAIGHTEN_OUT: d = 7'd20;
        STG_DRIVE_PAST:     d = 7'd30;
        STG_TURN_IN:        d = 7'd15;
        default:            d = '0;
      endcase
    end else if (tgt == TGT_RIGHT) begin
      unique case (stg)
        STG_TURN_OUT:       d = 7'd20;
        STG_STRAIGHTEN_OUT: d = 7'd100;
        STG_DRIVE_PAST:     d = 7'd40;
        STG_TURN_IN:        d = 7'd20;
        default:            d = '0;
      endcase
    end
    return d;
  endfunction

  function automatic logic stage_acts(target_t tgt, stage_t stg);
    logic a;
    a = 1'b0;
    if (tgt == TGT_LEFT || tgt == TGT_RIGHT) begin
      a = (stg >= STG_TURN_OUT) && (stg <= STG_STRAIGHTEN_IN);
    end else if (tgt == TGT_STRAIGHT) begin
      a = (stg == STG_DRIVE_PAST);
    end
    return a;
  endfunction

endpackage

/* rtl/tams_if.sv */
interface tams_in_if;
  import tams_pkg::*;
  logic    valid;
  logic    ready;
  func_t   func;
  target_t target_kind;

  modport source (output valid, output func, output target_kind, input ready);
  modport sink (input valid, input func, input target_kind, output ready);
endinterface

interface tams_out_if;
  logic              valid;
  logic              ready;
  logic signed [2:0] steer_override;
  logic              busy_res;
  logic [2:0]        stage_now;
  logic              start_taken;

  modport source (output valid, output steer_override, output busy_res,
                  output stage_now, output start_taken, input ready);
  modport sink (input valid, input steer_override, input busy_res,
                input stage_now, input start_taken, output ready);
endinterface

interface tams_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tams_in_reg.sv */
module tams_in_reg
  import tams_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tams_in_if.sink   in_if,
  input  logic      advance,
  output logic      item_vld,
  output item_t     item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  assign in_if.ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_if.ready) vld_nxt = in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r.func        <= in_if.func;
      item_r.target_kind <= in_if.target_kind;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

/* rtl/tams_core.sv */
module tams_core
  import tams_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  item_t     item,
  output logic      advance,
  tams_cfg_if.sink  cfg_if,
  tams_out_if.source out_if
);

  logic                fixed_mode_r;
  stage_t              stage_r, stage_nxt;
  target_t             tgt_r, tgt_nxt;
  logic [TicksW-1:0]   ticks_r, ticks_nxt;
  logic signed [2:0]   ovr_r, ovr_nxt;
  logic                taken_nxt;
  logic [TicksW-1:0]   ticks_dec;
  logic                step;

  logic                out_vld_r;
  logic signed [2:0]   out_steer_r;
  logic                out_busy_r;
  stage_t              out_stage_r;
  logic                out_taken_r;

  assign advance      = !out_vld_r || out_if.ready;
  assign step         = item_vld && advance;
  assign cfg_if.ready = 1'b1;

  assign ticks_dec = (ticks_r != '0) ? ticks_r - 1'b1 : ticks_r;

  always_comb begin
    stage_nxt = stage_r;
    tgt_nxt   = tgt_r;
    ticks_nxt = ticks_r;
    ovr_nxt   = ovr_r;
    taken_nxt = 1'b0;
    unique case (item.func)
      FUNC_TICK: begin
        if (fixed_mode_r && stage_r != STG_IDLE) begin
          ticks_nxt = ticks_dec;
          if (stage_acts(tgt_r, stage_r)) begin
            ovr_nxt = steer_of(tgt_r, stage_r);
            if (ticks_dec == '0) begin
              if (tgt_r == TGT_STRAIGHT || stage_r == STG_STRAIGHTEN_IN) begin
                stage_nxt = STG_IDLE;
                tgt_nxt   = TGT_NONE;
                ticks_nxt = '0;
                ovr_nxt   = SteerZero;
              end else begin
                ticks_nxt = next_dur(tgt_r, stage_r);
                stage_nxt = stage_t'(stage_r + 3'd1);
              end
            end
          end
        end
      end
      FUNC_START: begin
        if (stage_r == STG_IDLE && item.target_kind != TGT_NONE) begin
          tgt_nxt   = item.target_kind;
          taken_nxt = 1'b1;
          if (item.target_kind == TGT_STRAIGHT) begin
            stage_nxt = STG_DRIVE_PAST;
            ticks_nxt = DurStraight;
          end else begin
            stage_nxt = STG_TURN_OUT;
            ticks_nxt = DurFirst;
          end
        end
      end
      FUNC_STOP: begin
        stage_nxt = STG_IDLE;
        tgt_nxt   = TGT_NONE;
        ticks_nxt = '0;
        ovr_nxt   = SteerZero;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_mode_r <= 1'b1;
      stage_r      <= STG_IDLE;
      tgt_r        <= TGT_NONE;
      ticks_r      <= '0;
      ovr_r        <= SteerZero;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_if.valid) fixed_mode_r <= cfg_if.data;
      if (step) begin
        stage_r <= stage_nxt;
        tgt_r   <= tgt_nxt;
        ticks_r <= ticks_nxt;
        ovr_r   <= ovr_nxt;
      end
      if (advance) out_vld_r <= item_vld;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_steer_r <= ovr_nxt;
      out_busy_r  <= (stage_nxt != STG_IDLE);
      out_stage_r <= stage_nxt;
      out_taken_r <= taken_nxt;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.steer_override = out_steer_r;
  assign out_if.busy_res       = out_busy_r;
  assign out_if.stage_now      = out_stage_r;
  assign out_if.start_taken    = out_taken_r;

endmodule

/* rtl/timed_avoidance_maneuver_sequencer.sv */
// an event beat passes through the event register and then the result register,
// which holds the result beat until it is taken
// throughput: one event per cycle, held back only while the result register stalls
// the event register and the state update stage each carry only short logic
// reset: synchronous, active low; sequencer idle, override 0, fixed mode on
module timed_avoidance_maneuver_sequencer
  import tams_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tams_in_if.sink    in_if,
  tams_out_if.source out_if,
  tams_cfg_if.sink   cfg_if
);

  logic  item_vld;
  item_t item;
  logic  advance;

  tams_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  tams_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .advance  (advance),
    .cfg_if   (cfg_if),
    .out_if   (out_if)
  );

endmodule
